>>> rtl/core/kbd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard decoder package
// Scancode constants, result codes, flag and key types, and the set 1
// character tables shared by the keyboard scancode decoder.
// ----------------------------------------------------------------------------
package kbd_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned CHAR_W  = 8;
    localparam int unsigned KIND_W  = 2;
    localparam int unsigned TAB_IDX_W = 6;

    // Last scancode covered by the character tables, plus one.
    localparam logic [CODE_W-1:0] TAB_LEN = 8'h3A;

    // Modifier make and break codes.
    localparam logic [CODE_W-1:0] SC_LSHIFT_MK = 8'h2A;
    localparam logic [CODE_W-1:0] SC_RSHIFT_MK = 8'h36;
    localparam logic [CODE_W-1:0] SC_LSHIFT_BR = 8'hAA;
    localparam logic [CODE_W-1:0] SC_RSHIFT_BR = 8'hB6;
    localparam logic [CODE_W-1:0] SC_CAPS_MK   = 8'h3A;
    localparam logic [CODE_W-1:0] SC_CTRL_MK   = 8'h1D;
    localparam logic [CODE_W-1:0] SC_CTRL_BR   = 8'h9D;
    localparam logic [CODE_W-1:0] SC_ALT_MK    = 8'h38;
    localparam logic [CODE_W-1:0] SC_ALT_BR    = 8'hB8;
    localparam logic [CODE_W-1:0] SC_EXT_PFX   = 8'hE0;
    localparam logic [CODE_W-1:0] SC_WIN_KEY   = 8'h5B;

    // Arrow keys and the characters they produce.
    localparam logic [CODE_W-1:0] SC_LEFT  = 8'h4B;
    localparam logic [CODE_W-1:0] SC_UP    = 8'h48;
    localparam logic [CODE_W-1:0] SC_DOWN  = 8'h50;
    localparam logic [CODE_W-1:0] SC_RIGHT = 8'h4D;

    localparam logic [CHAR_W-1:0] CH_LEFT  = 8'hFC;
    localparam logic [CHAR_W-1:0] CH_UP    = 8'hFD;
    localparam logic [CHAR_W-1:0] CH_DOWN  = 8'hFE;
    localparam logic [CHAR_W-1:0] CH_RIGHT = 8'hFF;

    localparam logic [CHAR_W-1:0] CH_NONE     = 8'h00;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_CASE_MSK = 8'hDF;

    typedef enum logic [KIND_W-1:0] {
        EV_CHAR  = 2'd0,
        EV_MOD   = 2'd1,
        EV_KEYUP = 2'd2
    } t_event_kind;

    typedef struct packed {
        logic shift;
        logic caps;
        logic ctrl;
        logic alt;
    } t_mods;

    typedef struct packed {
        t_event_kind         kind;
        logic [CHAR_W-1:0]   char_code;
    } t_key_info;

    // Unshifted character for scancodes below TAB_LEN; zero means no character.
    function automatic logic [CHAR_W-1:0] f_plain_char(input logic [TAB_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            6'h01: c = 8'h1B;
            6'h02: c = 8'h31;
            6'h03: c = 8'h32;
            6'h04: c = 8'h33;
            6'h05: c = 8'h34;
            6'h06: c = 8'h35;
            6'h07: c = 8'h36;
            6'h08: c = 8'h37;
            6'h09: c = 8'h38;
            6'h0A: c = 8'h39;
            6'h0B: c = 8'h30;
            6'h0C: c = 8'h2D;
            6'h0D: c = 8'h3D;
            6'h0E: c = 8'h08;
            6'h0F: c = 8'h0B;
            6'h10: c = 8'h71;
            6'h11: c = 8'h77;
            6'h12: c = 8'h65;
            6'h13: c = 8'h72;
            6'h14: c = 8'h74;
            6'h15: c = 8'h79;
            6'h16: c = 8'h75;
            6'h17: c = 8'h69;
            6'h18: c = 8'h6F;
            6'h19: c = 8'h70;
            6'h1A: c = 8'h5B;
            6'h1B: c = 8'h5D;
            6'h1C: c = 8'h0A;
            6'h1E: c = 8'h61;
            6'h1F: c = 8'h73;
            6'h20: c = 8'h64;
            6'h21: c = 8'h66;
            6'h22: c = 8'h67;
            6'h23: c = 8'h68;
            6'h24: c = 8'h6A;
            6'h25: c = 8'h6B;
            6'h26: c = 8'h6C;
            6'h27: c = 8'h3B;
            6'h28: c = 8'h27;
            6'h29: c = 8'h60;
            6'h2B: c = 8'h5C;
            6'h2C: c = 8'h7A;
            6'h2D: c = 8'h78;
            6'h2E: c = 8'h63;
            6'h2F: c = 8'h76;
            6'h30: c = 8'h62;
            6'h31: c = 8'h6E;
            6'h32: c = 8'h6D;
            6'h33: c = 8'h2C;
            6'h34: c = 8'h2E;
            6'h35: c = 8'h2F;
            6'h39: c = 8'h20;
            default: c = CH_NONE;
        endcase
        return c;
    endfunction

    // Shifted symbol for digit and punctuation keys; other keys keep the
    // plain character (letters are upper-cased by the caller).
    function automatic logic [CHAR_W-1:0] f_shift_char(input logic [TAB_IDX_W-1:0] idx);
        logic [CHAR_W-1:0] c;
        case (idx)
            6'h02: c = 8'h21;
            6'h03: c = 8'h40;
            6'h04: c = 8'h23;
            6'h05: c = 8'h24;
            6'h06: c = 8'h25;
            6'h07: c = 8'h5E;
            6'h08: c = 8'h26;
            6'h09: c = 8'h2A;
            6'h0A: c = 8'h28;
            6'h0B: c = 8'h29;
            6'h0C: c = 8'h5F;
            6'h0D: c = 8'h2B;
            6'h1A: c = 8'h7B;
            6'h1B: c = 8'h7D;
            6'h27: c = 8'h3A;
            6'h28: c = 8'h22;
            6'h29: c = 8'h7E;
            6'h2B: c = 8'h7C;
            6'h33: c = 8'h3C;
            6'h34: c = 8'h3E;
            6'h35: c = 8'h3F;
            default: c = f_plain_char(idx);
        endcase
        return c;
    endfunction

endpackage

>>> rtl/core/kbd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard decoder stream interfaces
// Valid/ready channels for incoming scancodes and outgoing key events.
// ----------------------------------------------------------------------------
interface kbd_scan_if
    import kbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CODE_W-1:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink   (input valid, input scan_code, output ready);
endinterface

interface kbd_event_if
    import kbd_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] event_kind;
    logic [CHAR_W-1:0] char_code;
    logic              shift_held;
    logic              caps_on;
    logic              ctrl_held;
    logic              alt_held;
    logic [CODE_W-1:0] raw_echo;

    modport source (output valid, output event_kind, output char_code, output shift_held,
                    output caps_on, output ctrl_held, output alt_held, output raw_echo,
                    input ready);
    modport sink   (input valid, input event_kind, input char_code, input shift_held,
                    input caps_on, input ctrl_held, input alt_held, input raw_echo,
                    output ready);
endinterface

>>> rtl/core/kbd_char_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard character map
// Classifies one scancode and looks up its character from the current
// shift and caps-lock flags.
// ----------------------------------------------------------------------------
module kbd_char_map
    import kbd_pkg::*;
(
    input  logic [CODE_W-1:0] i_code,
    input  logic              i_shift,
    input  logic              i_caps,
    output t_key_info         o_info
);

    logic [TAB_IDX_W-1:0] w_idx;
    logic [CHAR_W-1:0]    w_plain;
    logic [CHAR_W-1:0]    w_shifted;
    logic                 w_letter;
    logic                 w_upper;

    assign w_idx     = i_code[TAB_IDX_W-1:0];
    assign w_plain   = f_plain_char(w_idx);
    assign w_letter  = w_plain inside {[CH_LOWER_A:CH_LOWER_Z]};
    // Letters follow shift XOR caps; every other key follows shift alone.
    assign w_upper   = w_letter ? (i_shift ^ i_caps) : i_shift;
    assign w_shifted = w_letter ? (w_plain & CH_CASE_MSK) : f_shift_char(w_idx);

    always_comb begin
        o_info.kind      = EV_KEYUP;
        o_info.char_code = CH_NONE;
        case (i_code)
            SC_LSHIFT_MK, SC_RSHIFT_MK, SC_LSHIFT_BR, SC_RSHIFT_BR, SC_CAPS_MK,
            SC_CTRL_MK, SC_CTRL_BR, SC_ALT_MK, SC_ALT_BR, SC_EXT_PFX,
            SC_WIN_KEY: begin
                o_info.kind = EV_MOD;
            end
            SC_LEFT: begin
                o_info.kind      = EV_CHAR;
                o_info.char_code = CH_LEFT;
            end
            SC_UP: begin
                o_info.kind      = EV_CHAR;
                o_info.char_code = CH_UP;
            end
            SC_DOWN: begin
                o_info.kind      = EV_CHAR;
                o_info.char_code = CH_DOWN;
            end
            SC_RIGHT: begin
                o_info.kind      = EV_CHAR;
                o_info.char_code = CH_RIGHT;
            end
            default: begin
                if ((i_code < TAB_LEN) && (w_plain != CH_NONE)) begin
                    o_info.kind      = EV_CHAR;
                    o_info.char_code = w_upper ? w_shifted : w_plain;
                end
            end
        endcase
    end

endmodule

>>> rtl/core/kbd_mod_state.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard modifier state
// Holds the shift, caps-lock, control and alt flags and applies the
// modifier make and break codes as scancodes pass through.
// ----------------------------------------------------------------------------
module kbd_mod_state
    import kbd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [CODE_W-1:0] i_code,
    output t_mods             o_mods,
    output t_mods             o_mods_next
);

    t_mods r_mods;
    t_mods n_mods;

    always_comb begin
        n_mods = r_mods;
        case (i_code)
            SC_LSHIFT_MK, SC_RSHIFT_MK: n_mods.shift = 1'b1;
            SC_LSHIFT_BR, SC_RSHIFT_BR: n_mods.shift = 1'b0;
            SC_CAPS_MK:                 n_mods.caps  = ~r_mods.caps;
            SC_CTRL_MK:                 n_mods.ctrl  = 1'b1;
            SC_CTRL_BR:                 n_mods.ctrl  = 1'b0;
            SC_ALT_MK:                  n_mods.alt   = 1'b1;
            SC_ALT_BR, SC_EXT_PFX:      n_mods.alt   = 1'b0;
            default:                    n_mods = r_mods;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mods <= '0;
        end else if (i_advance) begin
            r_mods <= n_mods;
        end
    end

    assign o_mods      = r_mods;
    assign o_mods_next = n_mods;

endmodule

>>> rtl/core/keyboard_scancode_to_ascii.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard scancode to ASCII decoder
// Turns set 1 scancodes into key events carrying a character, the
// modifier flags and the scancode itself.
// ----------------------------------------------------------------------------
// Usage:
//   i_scan takes one scancode byte per transaction. o_event gives exactly one
//   event per scancode, in order: the event kind (character, modifier or
//   ignored key, key-up or unmapped), the character byte, the four modifier
//   flags as they stand after the scancode, and the scancode echoed back.
//   A scancode accepted on i_scan is held in the input register, decoded
//   through the character map and the modifier update, and its event is
//   loaded into the event register. Throughput is one scancode per cycle
//   while the receiver takes events; the flag register is the only loop.
//   The input register and the event register each hold one transaction,
//   so a stalled receiver fills both before i_scan.ready drops, and
//   nothing is lost or repeated. Synchronous reset clears all four flags
//   and empties both registers.
// ----------------------------------------------------------------------------
module keyboard_scancode_to_ascii
    import kbd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    kbd_scan_if.sink           i_scan,
    kbd_event_if.source        o_event
);

    logic              r_in_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_out_valid;
    t_key_info         r_info;
    t_mods             r_out_mods;
    logic [CODE_W-1:0] r_echo;

    logic              w_advance;
    t_key_info         w_info;
    t_mods             w_mods;
    t_mods             w_mods_next;

    assign w_advance   = r_in_valid && (!r_out_valid || o_event.ready);
    assign i_scan.ready = !r_in_valid || w_advance;

    kbd_char_map u_char_map (
        .i_code  (r_code),
        .i_shift (w_mods.shift),
        .i_caps  (w_mods.caps),
        .o_info  (w_info)
    );

    kbd_mod_state u_mod_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (w_advance),
        .i_code      (r_code),
        .o_mods      (w_mods),
        .o_mods_next (w_mods_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_scan.valid && i_scan.ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_scan.valid && i_scan.ready) begin
            r_code <= i_scan.scan_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_event.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_info     <= w_info;
            r_out_mods <= w_mods_next;
            r_echo     <= r_code;
        end
    end

    assign o_event.valid      = r_out_valid;
    assign o_event.event_kind = r_info.kind;
    assign o_event.char_code  = r_info.char_code;
    assign o_event.shift_held = r_out_mods.shift;
    assign o_event.caps_on    = r_out_mods.caps;
    assign o_event.ctrl_held  = r_out_mods.ctrl;
    assign o_event.alt_held   = r_out_mods.alt;
    assign o_event.raw_echo   = r_echo;

endmodule

>>> rtl/core/kbd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keyboard decoder checker
// Port-level checks on the key event stream of the scancode decoder.
// ----------------------------------------------------------------------------
module kbd_checker
    import kbd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_ev_valid,
    input logic              i_ev_ready,
    input logic [KIND_W-1:0] i_ev_kind,
    input logic [CHAR_W-1:0] i_ev_char,
    input logic              i_ev_shift,
    input logic              i_ev_alt,
    input logic [CODE_W-1:0] i_ev_echo
);

    // Nothing is offered in the cycle right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_ev_valid)
        else $error("event valid right after reset");

    // A stalled event keeps its scancode until taken.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && !i_ev_ready |=> i_ev_valid && $stable(i_ev_echo))
        else $error("stalled event changed");

    // Events other than characters carry a zero character byte.
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && (i_ev_kind != EV_CHAR) |-> i_ev_char == CH_NONE)
        else $error("nonzero character on non-character event");

    // Shift make and break codes show their effect in their own event.
    a_shift_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid |-> ((i_ev_echo != SC_LSHIFT_MK && i_ev_echo != SC_RSHIFT_MK) || i_ev_shift)
                    && ((i_ev_echo != SC_LSHIFT_BR && i_ev_echo != SC_RSHIFT_BR) || !i_ev_shift))
        else $error("shift flag does not follow shift scancode");

    // Alt break and the extended prefix both leave alt released.
    a_alt_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ev_valid && (i_ev_echo == SC_ALT_BR || i_ev_echo == SC_EXT_PFX) |-> !i_ev_alt)
        else $error("alt still held after release code");

endmodule

bind keyboard_scancode_to_ascii kbd_checker u_kbd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_ev_valid (o_event.valid),
    .i_ev_ready (o_event.ready),
    .i_ev_kind  (o_event.event_kind),
    .i_ev_char  (o_event.char_code),
    .i_ev_shift (o_event.shift_held),
    .i_ev_alt   (o_event.alt_held),
    .i_ev_echo  (o_event.raw_echo)
);
